// File: hw/rtl/i2a_pkg.sv
// Shared constants, action codes and character helpers for the integer to ASCII formatter.
package i2a_pkg;

  // Largest honored hex pad request
  localparam int PAD_LIMIT = 32;
  localparam int PAD_W     = $clog2(PAD_LIMIT + 1);

  // Operand and digit register geometry
  localparam int VAL_W      = 64;
  localparam int DEC_DIGITS = 20;
  localparam int HEX_DIGITS = VAL_W / 4;
  localparam int DIG_W      = DEC_DIGITS * 4;
  localparam int NDIG_W     = $clog2(DEC_DIGITS + 1);
  localparam int STEP_W     = $clog2(VAL_W);

  // Format actions
  localparam logic [1:0] ACT_UDEC = 2'd0;
  localparam logic [1:0] ACT_SDEC = 2'd1;
  localparam logic [1:0] ACT_HEXL = 2'd2;
  localparam logic [1:0] ACT_HEXU = 2'd3;

  // Fixed characters
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_MINUS = 7'h2d;
  localparam logic [6:0] CHAR_UPA   = 7'h41;
  localparam logic [6:0] CHAR_LOWA  = 7'h61;

  // One digit (0..15) to its ASCII code
  function automatic logic [6:0] nib_char(input logic [3:0] nib, input logic upper);
    logic [6:0] ch;
    if (nib < 4'd10) begin
      ch = CHAR_ZERO + {3'd0, nib};
    end else if (upper) begin
      ch = CHAR_UPA + {3'd0, nib} - 7'd10;
    end else begin
      ch = CHAR_LOWA + {3'd0, nib} - 7'd10;
    end
    return ch;
  endfunction

endpackage

// File: hw/rtl/i2a_bcd.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module i2a_bcd (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [i2a_pkg::VAL_W-1:0] bin,
  output logic                      done,
  output logic [i2a_pkg::DIG_W-1:0] bcd
);
  import i2a_pkg::*;

  logic [VAL_W-1:0]  bin_r, bin_nxt;
  logic [DIG_W-1:0]  bcd_r, bcd_nxt;
  logic [DIG_W-1:0]  adj;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  // Add 3 to every digit of 5 or more ahead of the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // Sequencer: load, then 64 shift steps
  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = bin;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {adj[DIG_W-2:0], bin_r[VAL_W-1]};
      bin_nxt = {bin_r[VAL_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(VAL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

// File: hw/rtl/integer_to_ascii_formatter.sv
// Top level: formats a 64-bit value as decimal or hex ASCII, one character per output request.
//
// Input channel (in_valid / in_stall): one request carries in_value, in_action and
// in_min_digits. in_stall stays high from acceptance until the last character of the
// request has been loaded into the output register, so one request is worked at a time.
// Output channel (out_valid / out_stall): one character per transfer, most significant
// first, out_last_char set on the final one. The output register lets the next input
// request be accepted while the final character still waits to be taken.
// Timing: decimal runs the serial BCD converter, one bit per cycle, then drops leading
// zero digits one per cycle (up to 19) and emits one character per cycle (up to 20) while
// the receiver does not stall. Hex skips leading zero nibbles (up to 15), then emits pad
// zeros and digits, one per cycle while the receiver does not stall (up to 32). The
// next request can be accepted in the cycle after the final character enters the output
// register. The BCD shift loop dominates decimal requests, the pad count hex ones.
// When the receiver stalls, character emission simply pauses; nothing is lost.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid.
module integer_to_ascii_formatter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [i2a_pkg::VAL_W-1:0] in_value,
  input  logic [1:0]                in_action,
  input  logic [5:0]                in_min_digits,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [6:0]                out_char_code,
  output logic                      out_last_char
);
  import i2a_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CONV, S_SKIP, S_SIGN, S_PAD, S_DIGIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [DIG_W-1:0]  dig_r, dig_nxt;
  logic [NDIG_W-1:0] ndig_r, ndig_nxt;
  logic [PAD_W-1:0]  want_r, want_nxt;
  logic [PAD_W-1:0]  pad_r, pad_nxt;
  logic              neg_r, neg_nxt;
  logic              upper_r, upper_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [6:0]        out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  logic              bcd_start;
  logic              bcd_done;
  logic [DIG_W-1:0]  bcd_val;
  logic [VAL_W-1:0]  mag;
  logic              in_neg;
  logic [PAD_W-1:0]  want_in;
  logic [PAD_W-1:0]  ndig_ext;
  logic              out_free;
  logic              emit;
  logic [6:0]        emit_char;
  logic              emit_last;

  // Request decode: sign, magnitude and saturated pad count
  assign in_neg  = (in_action == ACT_SDEC) && in_value[VAL_W-1];
  assign mag     = in_neg ? (~in_value + 1'b1) : in_value;
  assign want_in = ({1'b0, in_min_digits} > 7'(PAD_LIMIT)) ? PAD_W'(PAD_LIMIT)
                                                          : PAD_W'(in_min_digits);
  assign ndig_ext = PAD_W'(ndig_r);

  assign in_stall  = (state_r != S_IDLE);
  assign bcd_start = in_valid && (state_r == S_IDLE) && !in_action[1];
  assign out_free  = !out_valid_r || !out_stall;

  i2a_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bcd_start),
    .bin   (mag),
    .done  (bcd_done),
    .bcd   (bcd_val)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    dig_nxt   = dig_r;
    ndig_nxt  = ndig_r;
    want_nxt  = want_r;
    pad_nxt   = pad_r;
    neg_nxt   = neg_r;
    upper_nxt = upper_r;
    emit      = 1'b0;
    emit_char = CHAR_ZERO;
    emit_last = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          neg_nxt   = in_neg;
          upper_nxt = (in_action == ACT_HEXU);
          if (in_action[1]) begin
            dig_nxt   = {in_value, {(DIG_W - VAL_W){1'b0}}};
            ndig_nxt  = NDIG_W'(HEX_DIGITS);
            want_nxt  = want_in;
            state_nxt = S_SKIP;
          end else begin
            want_nxt  = '0;
            state_nxt = S_CONV;
          end
        end
      end
      S_CONV: begin
        if (bcd_done) begin
          dig_nxt   = bcd_val;
          ndig_nxt  = NDIG_W'(DEC_DIGITS);
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        // Drop one leading zero digit per cycle, keeping at least one
        if (ndig_r > NDIG_W'(1) && dig_r[DIG_W-1 -: 4] == 4'd0) begin
          dig_nxt  = {dig_r[DIG_W-5:0], 4'd0};
          ndig_nxt = ndig_r - 1'b1;
        end else begin
          pad_nxt = (ndig_ext < want_r) ? (want_r - ndig_ext) : '0;
          if (neg_r) begin
            state_nxt = S_SIGN;
          end else if (ndig_ext < want_r) begin
            state_nxt = S_PAD;
          end else begin
            state_nxt = S_DIGIT;
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CHAR_MINUS;
          state_nxt = S_DIGIT;
        end
      end
      S_PAD: begin
        if (out_free) begin
          emit    = 1'b1;
          pad_nxt = pad_r - 1'b1;
          if (pad_r == PAD_W'(1)) begin
            state_nxt = S_DIGIT;
          end
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = nib_char(dig_r[DIG_W-1 -: 4], upper_r);
          emit_last = (ndig_r == NDIG_W'(1));
          dig_nxt   = {dig_r[DIG_W-5:0], 4'd0};
          ndig_nxt  = ndig_r - 1'b1;
          if (ndig_r == NDIG_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = emit ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
    out_char_nxt  = emit ? emit_char : out_char_r;
    out_last_nxt  = emit ? emit_last : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dig_r      <= dig_nxt;
    ndig_r     <= ndig_nxt;
    want_r     <= want_nxt;
    pad_r      <= pad_nxt;
    neg_r      <= neg_nxt;
    upper_r    <= upper_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

endmodule
